>>> rtl/core/rpn_pkg.sv
// shared types and constants for the rpn stack calculator
// no dependencies; imported by rpn_cell, rpn_alu and rpn_stack_calculator
package rpn_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int WORD_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int DIV_STEPS   = WORD_W + FRAC_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      OP_LOAD = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4,
      OP_SWAP = 3'd5,
      OP_DROP = 3'd6,
      OP_DUP  = 3'd7
   } opcode_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT_DOWN,
      CELL_SHIFT_UP,
      CELL_SET
   } cell_cmd_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] result;
      logic              saturated;
   } alu_rsp_type;

endpackage

>>> rtl/core/rpn_stack_calculator.sv
// top level of the rpn stack calculator: control, cell chain, arithmetic unit
// depends on rpn_pkg, rpn_cell, rpn_alu
//
// usage:
//   command channel: drive req_type and req_value with start high; the item is
//   taken at a rising edge where start is high and busy is low.
//   result channel: rsp_valid is high for exactly one cycle and carries the
//   new top and second entries plus the div_zero and saturated flags. the
//   receiver cannot stall; the result must be captured in that cycle.
// steps from the accept edge to the strobe:
//   load, swap, drop, dup and divide by zero: strobe registered straight from the accept
//   add, subtract: alu add state; multiply: alu multiply and rounding states
//   divide: the 48 step bit-serial quotient loop, then the alu finish state
// throughput: one item at a time; busy stays high until the result cycle
// ends, so the next item can be taken in the cycle after the strobe.
// reset: synchronous, clears every stack cell to zero and returns to idle.
// the stack is a chain of cells; every cell takes the word of a neighbor in the
// same cycle when the stack shifts, and zero enters at the bottom on an upward shift.
module rpn_stack_calculator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_type,
   input  logic signed [31:0]          req_value,
   output logic                        rsp_valid,
   output logic signed [31:0]          rsp_top,
   output logic signed [31:0]          rsp_second,
   output logic                        rsp_div_zero,
   output logic                        rsp_saturated
);
   import rpn_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ALU,
      S_RESP
   } state_type;

   state_type          state_ff;
   logic               rsp_valid_ff;
   logic               div_zero_ff;
   logic               saturated_ff;

   opcode_type         op;
   logic               accept;
   logic               top_zero;
   logic               arith;
   logic               alu_start;
   alu_rsp_type        alu_rsp;

   logic [WORD_W-1:0]  cell_data [STACK_DEPTH];
   cell_cmd_type       cell_cmd  [STACK_DEPTH];
   logic [WORD_W-1:0]  push_data;
   logic [WORD_W-1:0]  top_set;

   assign op       = opcode_type'(req_type);
   assign accept   = start && (state_ff == S_IDLE);
   assign top_zero = (cell_data[0] == '0);
   // divide by zero skips the arithmetic unit and leaves the stack alone
   assign arith    = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) ||
                     ((op == OP_DIV) && !top_zero);
   assign alu_start = accept && arith;

   // load pushes the new value, dup pushes a copy of the top
   assign push_data = (op == OP_LOAD) ? req_value : cell_data[0];
   // top cell takes the arithmetic result or, on swap, the second entry
   assign top_set   = alu_rsp.done ? alu_rsp.result : cell_data[1];

   // per-cell shift commands
   always_comb begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
         cell_cmd[i] = CELL_HOLD;
         if (alu_rsp.done) begin
            // result replaces the top, the rest close the gap upward
            cell_cmd[i] = (i == 0) ? CELL_SET : CELL_SHIFT_UP;
         end else if (accept) begin
            case (op)
               OP_LOAD, OP_DUP: cell_cmd[i] = CELL_SHIFT_DOWN;
               OP_DROP:         cell_cmd[i] = CELL_SHIFT_UP;
               OP_SWAP:         cell_cmd[i] = (i < 2) ? CELL_SET : CELL_HOLD;
               default:         cell_cmd[i] = CELL_HOLD;
            endcase
         end
      end
   end

   // the chain of cells, top at index 0, zero fed in below the bottom
   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
      logic [WORD_W-1:0] shallower;
      logic [WORD_W-1:0] deeper;
      logic [WORD_W-1:0] set_val;

      if (g == 0) begin : g_top
         assign shallower = push_data;
         assign set_val   = top_set;
      end else begin : g_inner
         assign shallower = cell_data[g-1];
         // only the second cell is ever set directly (swap)
         assign set_val   = (g == 1) ? cell_data[0] : '0;
      end

      if (g == STACK_DEPTH - 1) begin : g_bottom
         assign deeper = '0;
      end else begin : g_mid
         assign deeper = cell_data[g+1];
      end

      rpn_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .cmd            (cell_cmd[g]),
         .shallower_data (shallower),
         .deeper_data    (deeper),
         .set_data       (set_val),
         .data           (cell_data[g])
      );
   end

   rpn_alu u_alu (
      .clock (clock),
      .reset (reset),
      .start (alu_start),
      .op    (op),
      .opa   (cell_data[1]),
      .opb   (cell_data[0]),
      .rsp   (alu_rsp)
   );

   // control: idle -> (alu) -> result strobe -> idle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         div_zero_ff  <= 1'b0;
         saturated_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  div_zero_ff  <= (op == OP_DIV) && top_zero;
                  saturated_ff <= 1'b0;
                  if (arith) begin
                     state_ff <= S_ALU;
                  end else begin
                     state_ff     <= S_RESP;
                     rsp_valid_ff <= 1'b1;
                  end
               end
            end
            S_ALU: begin
               if (alu_rsp.done) begin
                  saturated_ff <= alu_rsp.saturated;
                  state_ff     <= S_RESP;
                  rsp_valid_ff <= 1'b1;
               end
            end
            S_RESP: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top       = cell_data[0];
   assign rsp_second    = cell_data[1];
   assign rsp_div_zero  = div_zero_ff;
   assign rsp_saturated = saturated_ff;

endmodule

>>> rtl/core/rpn_cell.sv
// one stack cell: holds a word and trades it with its neighbors
// depends on rpn_pkg
module rpn_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  rpn_pkg::cell_cmd_type           cmd,
   input  logic [rpn_pkg::WORD_W-1:0]      shallower_data,
   input  logic [rpn_pkg::WORD_W-1:0]      deeper_data,
   input  logic [rpn_pkg::WORD_W-1:0]      set_data,
   output logic [rpn_pkg::WORD_W-1:0]      data
);
   import rpn_pkg::*;

   logic [WORD_W-1:0] data_ff;
   logic [WORD_W-1:0] data_in;

   always_comb begin
      unique case (cmd)
         CELL_SHIFT_DOWN: data_in = shallower_data;
         CELL_SHIFT_UP:   data_in = deeper_data;
         CELL_SET:        data_in = set_data;
         default:         data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

>>> rtl/core/rpn_alu.sv
// q16.16 arithmetic unit: saturating add/sub, rounded saturating multiply,
// bit-serial restoring divide with saturation; depends on rpn_pkg
module rpn_alu (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  rpn_pkg::opcode_type          op,
   input  logic [rpn_pkg::WORD_W-1:0]   opa,
   input  logic [rpn_pkg::WORD_W-1:0]   opb,
   output rpn_pkg::alu_rsp_type         rsp
);
   import rpn_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_MUL,
      ST_RND,
      ST_DIV,
      ST_DFIN
   } state_type;

   localparam logic [WORD_W-1:0] MAX_WORD = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic [WORD_W-1:0] MIN_WORD = {1'b1, {(WORD_W-1){1'b0}}};

   state_type                  state_ff;
   logic                       sub_ff;
   logic signed [WORD_W-1:0]   a_ff, b_ff;
   logic signed [2*WORD_W-1:0] prod_ff;
   logic [DIV_STEPS-1:0]       quot_ff;
   logic [WORD_W-1:0]          rem_ff;
   logic [WORD_W-1:0]          divisor_ff;
   logic                       neg_ff;
   logic [DIV_CNT_W-1:0]       cnt_ff;
   alu_rsp_type                rsp_ff;

   logic [WORD_W-1:0]          abs_a, abs_b;
   logic signed [WORD_W:0]     sum;
   logic signed [2*WORD_W-1:0] rnd;
   logic [2*WORD_W-FRAC_W-1:0] rnd_hi;
   logic [WORD_W:0]            trial;
   logic [WORD_W:0]            trial_diff;
   logic                       q_bit;

   always_comb begin
      abs_a = opa[WORD_W-1] ? WORD_W'(-opa) : opa;
      abs_b = opb[WORD_W-1] ? WORD_W'(-opb) : opb;
      sum   = sub_ff ? ({a_ff[WORD_W-1], a_ff} - {b_ff[WORD_W-1], b_ff})
                     : ({a_ff[WORD_W-1], a_ff} + {b_ff[WORD_W-1], b_ff});
      rnd    = prod_ff + (2*WORD_W)'(1 << (FRAC_W - 1));
      rnd_hi = rnd[2*WORD_W-1:FRAC_W];
      trial      = {rem_ff, quot_ff[DIV_STEPS-1]};
      trial_diff = trial - {1'b0, divisor_ff};
      q_bit      = !trial_diff[WORD_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_ff   <= '0;
      end else begin
         rsp_ff.done <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  a_ff       <= opa;
                  b_ff       <= opb;
                  sub_ff     <= (op == OP_SUB);
                  quot_ff    <= {abs_a, {FRAC_W{1'b0}}};
                  rem_ff     <= '0;
                  divisor_ff <= abs_b;
                  neg_ff     <= opa[WORD_W-1] ^ opb[WORD_W-1];
                  cnt_ff     <= '0;
                  unique case (op)
                     OP_MUL:  state_ff <= ST_MUL;
                     OP_DIV:  state_ff <= ST_DIV;
                     default: state_ff <= ST_ADD;
                  endcase
               end
            end
            ST_ADD: begin
               rsp_ff.done <= 1'b1;
               if (sum[WORD_W] != sum[WORD_W-1]) begin
                  rsp_ff.saturated <= 1'b1;
                  rsp_ff.result    <= sum[WORD_W] ? MIN_WORD : MAX_WORD;
               end else begin
                  rsp_ff.saturated <= 1'b0;
                  rsp_ff.result    <= sum[WORD_W-1:0];
               end
               state_ff <= ST_IDLE;
            end
            ST_MUL: begin
               prod_ff  <= (2*WORD_W)'(a_ff) * (2*WORD_W)'(b_ff);
               state_ff <= ST_RND;
            end
            ST_RND: begin
               rsp_ff.done <= 1'b1;
               // in range only when every bit above the sign matches it
               if ((&rnd_hi[2*WORD_W-FRAC_W-1:WORD_W-1]) ||
                   !(|rnd_hi[2*WORD_W-FRAC_W-1:WORD_W-1])) begin
                  rsp_ff.saturated <= 1'b0;
                  rsp_ff.result    <= rnd_hi[WORD_W-1:0];
               end else begin
                  rsp_ff.saturated <= 1'b1;
                  rsp_ff.result    <= rnd_hi[2*WORD_W-FRAC_W-1] ? MIN_WORD : MAX_WORD;
               end
               state_ff <= ST_IDLE;
            end
            ST_DIV: begin
               rem_ff  <= q_bit ? trial_diff[WORD_W-1:0] : trial[WORD_W-1:0];
               quot_ff <= {quot_ff[DIV_STEPS-2:0], q_bit};
               cnt_ff  <= cnt_ff + 1'b1;
               if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_DFIN;
               end
            end
            ST_DFIN: begin
               rsp_ff.done <= 1'b1;
               if (neg_ff) begin
                  if (quot_ff > DIV_STEPS'({1'b0, MIN_WORD})) begin
                     rsp_ff.saturated <= 1'b1;
                     rsp_ff.result    <= MIN_WORD;
                  end else begin
                     rsp_ff.saturated <= 1'b0;
                     rsp_ff.result    <= WORD_W'(-quot_ff[WORD_W-1:0]);
                  end
               end else begin
                  if (quot_ff > DIV_STEPS'({1'b0, MAX_WORD})) begin
                     rsp_ff.saturated <= 1'b1;
                     rsp_ff.result    <= MAX_WORD;
                  end else begin
                     rsp_ff.saturated <= 1'b0;
                     rsp_ff.result    <= quot_ff[WORD_W-1:0];
                  end
               end
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp = rsp_ff;

endmodule
